// File: rtl/core/sarp_pkg.sv
// Shared types, constants and helper functions for the sensor report parser.
`default_nettype none

package sarp_pkg;

   localparam int CHAR_W     = 8;
   localparam int VAL_W      = 16;
   localparam int LEN_W      = 8;
   localparam int KW_CNT_W   = 4;
   localparam int SLOT_COUNT = 3;
   localparam int SLOT_W     = 2;
   localparam int RSP_DATA_W = SLOT_COUNT * VAL_W + LEN_W;

   // Keyword texts, first character in the top byte
   localparam int KW_DIST_LEN  = 9;
   localparam int KW_MM_LEN    = 2;
   localparam int KW_NOISE_LEN = 6;
   localparam int KW_CONF_LEN  = 11;
   localparam logic [8*KW_DIST_LEN-1:0]  KW_DIST  = "Distance:";
   localparam logic [8*KW_MM_LEN-1:0]    KW_MM    = "mm";
   localparam logic [8*KW_NOISE_LEN-1:0] KW_NOISE = "Noise:";
   localparam logic [8*KW_CONF_LEN-1:0]  KW_CONF  = "Confidence:";

   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   localparam logic [SLOT_W-1:0] SLOT_DIST  = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_NOISE = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_CONF  = 2'd2;

   // Which keyword is being hunted
   typedef enum logic [2:0] {
      PH_DIST,
      PH_MM,
      PH_NOISE,
      PH_CONF,
      PH_DONE
   } phase_type;

   typedef logic [VAL_W-1:0] value_type;
   typedef value_type [SLOT_COUNT-1:0] value_set_type;

   // Per-byte control from the top level
   typedef struct packed {
      logic en;     // byte lies inside the length limit
      logic clear;  // frame closes after this byte
   } step_type;

   // Keyword matcher status
   typedef struct packed {
      phase_type phase;       // phase before this byte
      phase_type phase_next;  // phase after this byte
      logic      hit;         // keyword completed on this byte
   } kw_status_type;

   function automatic logic [KW_CNT_W-1:0] kw_len(input phase_type ph);
      logic [KW_CNT_W-1:0] n;
      n = '0;
      case (ph)
         PH_DIST:  n = KW_CNT_W'(KW_DIST_LEN);
         PH_MM:    n = KW_CNT_W'(KW_MM_LEN);
         PH_NOISE: n = KW_CNT_W'(KW_NOISE_LEN);
         PH_CONF:  n = KW_CNT_W'(KW_CONF_LEN);
         default:  n = '0;
      endcase
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] kw_char(input phase_type ph,
                                                 input logic [KW_CNT_W-1:0] idx);
      logic [CHAR_W-1:0] ch;
      ch = '0;
      case (ph)
         PH_DIST: begin
            if (idx < KW_CNT_W'(KW_DIST_LEN))
               ch = KW_DIST[8*(KW_DIST_LEN-1-int'(idx)) +: 8];
         end
         PH_MM: begin
            if (idx < KW_CNT_W'(KW_MM_LEN))
               ch = KW_MM[8*(KW_MM_LEN-1-int'(idx)) +: 8];
         end
         PH_NOISE: begin
            if (idx < KW_CNT_W'(KW_NOISE_LEN))
               ch = KW_NOISE[8*(KW_NOISE_LEN-1-int'(idx)) +: 8];
         end
         PH_CONF: begin
            if (idx < KW_CNT_W'(KW_CONF_LEN))
               ch = KW_CONF[8*(KW_CONF_LEN-1-int'(idx)) +: 8];
         end
         default: ch = '0;
      endcase
      return ch;
   endfunction

   function automatic phase_type phase_after(input phase_type ph);
      phase_type n;
      case (ph)
         PH_DIST:  n = PH_MM;
         PH_MM:    n = PH_NOISE;
         PH_NOISE: n = PH_CONF;
         default:  n = PH_DONE;
      endcase
      return n;
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/sarp_keyword_matcher.sv
// Sequential keyword matcher: tracks the hunted keyword and the matched prefix.
`default_nettype none

module sarp_keyword_matcher
   import sarp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire step_type          step,
   input  wire logic [CHAR_W-1:0] data_byte,
   output kw_status_type          status
);

   phase_type           phase_ff, phase_in;
   logic [KW_CNT_W-1:0] count_ff, count_in;
   logic [KW_CNT_W-1:0] idx;
   logic                hit;

   // Compare the byte against the expected keyword character
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      hit      = 1'b0;
      idx      = (count_ff < kw_len(phase_ff)) ? count_ff : '0;
      if (step.en && phase_ff != PH_DONE) begin
         if (data_byte == kw_char(phase_ff, idx)) begin
            count_in = idx + KW_CNT_W'(1);
         end else if (data_byte == kw_char(phase_ff, '0)) begin
            count_in = KW_CNT_W'(1);
         end else begin
            count_in = '0;
         end
         // Advance to the next keyword once the whole text matched
         if (count_in >= kw_len(phase_ff)) begin
            count_in = '0;
            phase_in = phase_after(phase_ff);
            hit      = 1'b1;
         end
      end
   end

   // Restart the hunt after the last byte of a frame
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DIST;
         count_ff <= '0;
      end else if (step.clear) begin
         phase_ff <= PH_DIST;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign status.phase      = phase_ff;
   assign status.phase_next = phase_in;
   assign status.hit        = hit;

endmodule

`default_nettype wire

// File: rtl/core/sarp_number_parser.sv
// Decimal field reader: whitespace skip, optional sign, digits modulo 2^16.
`default_nettype none

module sarp_number_parser
   import sarp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire step_type          step,
   input  wire logic [CHAR_W-1:0] data_byte,
   input  wire kw_status_type     status,
   output value_set_type          pending_next
);

   typedef enum logic [1:0] {
      NUM_SPACE,
      NUM_SIGN,
      NUM_DIGITS,
      NUM_IDLE
   } num_phase_type;

   num_phase_type     nphase_ff, nphase_in;
   logic              neg_ff, neg_in;
   value_type         acc_ff, acc_in;
   value_set_type     pend_ff, pend_in;
   logic [SLOT_W-1:0] slot;
   logic              slot_ok;
   logic              write;
   value_type         digit_val;

   // Map the hunted keyword to the value slot being read
   always_comb begin
      slot    = SLOT_DIST;
      slot_ok = 1'b0;
      case (status.phase)
         PH_MM: begin
            slot    = SLOT_DIST;
            slot_ok = 1'b1;
         end
         PH_CONF: begin
            slot    = SLOT_NOISE;
            slot_ok = 1'b1;
         end
         PH_DONE: begin
            slot    = SLOT_CONF;
            slot_ok = 1'b1;
         end
         default: begin
            slot    = SLOT_DIST;
            slot_ok = 1'b0;
         end
      endcase
   end

   assign digit_val = VAL_W'(data_byte[3:0]);

   // Step the number reader and update the pending value
   always_comb begin
      nphase_in = nphase_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      write     = 1'b0;
      if (step.en && slot_ok) begin
         case (nphase_ff)
            NUM_SPACE: begin
               if (is_space(data_byte)) begin
                  nphase_in = NUM_SPACE;
               end else if (data_byte == CH_PLUS) begin
                  nphase_in = NUM_SIGN;
               end else if (data_byte == CH_MINUS) begin
                  neg_in    = 1'b1;
                  nphase_in = NUM_SIGN;
               end else if (is_digit(data_byte)) begin
                  acc_in    = digit_val;
                  nphase_in = NUM_DIGITS;
                  write     = 1'b1;
               end else begin
                  nphase_in = NUM_IDLE;
               end
            end
            NUM_SIGN: begin
               if (is_digit(data_byte)) begin
                  acc_in    = digit_val;
                  nphase_in = NUM_DIGITS;
                  write     = 1'b1;
               end else begin
                  nphase_in = NUM_IDLE;
               end
            end
            NUM_DIGITS: begin
               if (is_digit(data_byte)) begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + digit_val;
                  write  = 1'b1;
               end else begin
                  nphase_in = NUM_IDLE;
               end
            end
            default: nphase_in = NUM_IDLE;
         endcase
         if (write)
            pend_in[slot] = neg_in ? (VAL_W'(0) - acc_in) : acc_in;
      end
      // Restart the reader after each keyword; nothing follows the mm text
      if (step.en && status.hit) begin
         neg_in    = 1'b0;
         acc_in    = '0;
         nphase_in = (status.phase == PH_MM) ? NUM_IDLE : NUM_SPACE;
      end
   end

   // Clear the reader and the pending values after the last byte of a frame
   always_ff @(posedge clock) begin
      if (reset) begin
         nphase_ff <= NUM_IDLE;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         pend_ff   <= '0;
      end else if (step.clear) begin
         nphase_ff <= NUM_IDLE;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         nphase_ff <= nphase_in;
         neg_ff    <= neg_in;
         acc_ff    <= acc_in;
         pend_ff   <= pend_in;
      end
   end

   assign pending_next = pend_in;

endmodule

`default_nettype wire

// File: rtl/core/sensor_ascii_report_parser.sv
// Top level of the range sensor text report parser.
//
//  Channel | Dir | Transfer          | Payload
//  req_    | in  | one report byte   | tdata = data_byte[7:0], tlast = last_byte
//  rsp_    | out | one frame summary | tuser = found, tdata = distance, noise,
//          |     |                   |         confidence, used_length
//
// Each byte is held in the input register and is folded into the frame state when
// it moves on; a byte can be taken every cycle while the input does not stall.
// A byte with tlast moves from the input register into the result register, which then holds its summary.
// The input stalls only when a last byte waits and the result register is full and not being taken.
// Reset is synchronous and clears the frame state and the held values.
`default_nettype none

module sensor_ascii_report_parser
   import sarp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 255
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [CHAR_W-1:0]     req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [15:0] distance, [31:16] noise,
                                                   // [47:32] confidence, [55:48] used_length
   output logic                       rsp_tuser    // [0] found
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   logic                  in_valid_ff;
   logic [CHAR_W-1:0]     in_byte_ff;
   logic                  in_last_ff;
   logic                  advance;
   step_type              step;
   kw_status_type         kw_status;
   value_set_type         pending_next;

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]      end_ff, end_in;
   value_set_type         held_ff, held_in;
   logic                  found;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;

   // Move the byte on unless it closes a frame and the result is still held
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign step.en    = advance && (pos_ff < POS_W'(MAX_FRAME_BYTES));
   assign step.clear = advance && in_last_ff;

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   sarp_keyword_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .status    (kw_status)
   );

   sarp_number_parser u_number (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .status       (kw_status),
      .pending_next (pending_next)
   );

   assign found = (kw_status.phase_next == PH_DONE);

   // Track the byte offset and the end of the confidence digits
   always_comb begin
      pos_in  = pos_ff;
      end_in  = end_ff;
      held_in = held_ff;
      if (step.en) begin
         pos_in = pos_ff + POS_W'(1);
         if (kw_status.hit && kw_status.phase == PH_CONF) begin
            end_in = pos_ff + POS_W'(1);
         end else if (kw_status.phase == PH_DONE && end_ff == pos_ff
                      && is_digit(in_byte_ff)) begin
            end_in = pos_ff + POS_W'(1);
         end
      end
      if (step.clear && found)
         held_in = pending_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         end_ff  <= '0;
         held_ff <= '0;
      end else begin
         pos_ff  <= step.clear ? '0 : pos_in;
         end_ff  <= step.clear ? '0 : end_in;
         held_ff <= held_in;
      end
   end

   // Load the frame summary, hold it until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step.clear) begin
         rsp_user_ff <= found;
         rsp_data_ff <= {(found ? LEN_W'(end_in) : LEN_W'(0)),
                         held_in[SLOT_CONF], held_in[SLOT_NOISE], held_in[SLOT_DIST]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire
